@@ rtl/core/hdlcfe_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hdlcfe_pkg
// Shared types, line codes and the CRC-16 byte update for the frame encoder.
// ----------------------------------------------------------------------------
package hdlcfe_pkg;

	localparam logic [7:0]  FLAG_BYTE = 8'h7E;
	localparam logic [7:0]  ESC_BYTE  = 8'h7D;
	localparam logic [7:0]  STUFF_XOR = 8'h20;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_data;
		logic       frame_first;
		logic       frame_last;
		logic [7:0] address;
		logic [7:0] control;
	} item_t;

	typedef struct packed {
		logic  vld;
		item_t item;
	} slot_t;

	typedef enum logic [2:0] {
		STEP_FLAG_OPEN,
		STEP_ADDR,
		STEP_ESC_HDR,
		STEP_CTRL,
		STEP_DATA,
		STEP_CRC_LO,
		STEP_CRC_HI,
		STEP_FLAG_CLOSE
	} step_t;

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/hdlcfe_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hdlcfe_in_if
// Request channel carrying one frame item per handshake.
// ----------------------------------------------------------------------------
interface hdlcfe_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_data;
	logic       frame_first;
	logic       frame_last;
	logic [7:0] address;
	logic [7:0] control;

	modport source (
		output valid, data_byte, has_data, frame_first, frame_last, address, control,
		input  ready
	);
	modport sink (
		input  valid, data_byte, has_data, frame_first, frame_last, address, control,
		output ready
	);
endinterface
`default_nettype wire

@@ rtl/core/hdlcfe_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hdlcfe_out_if
// Line channel carrying one encoded byte per handshake.
// ----------------------------------------------------------------------------
interface hdlcfe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       frame_end;

	modport source (
		output valid, out_byte, run_last, frame_end,
		input  ready
	);
	modport sink (
		input  valid, out_byte, run_last, frame_end,
		output ready
	);
endinterface
`default_nettype wire

@@ rtl/core/hdlcfe_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hdlcfe_front
// Input stage: registers requests and drops those that produce no bytes.
// ----------------------------------------------------------------------------
module hdlcfe_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	hdlcfe_in_if.sink          frame_req,
	output hdlcfe_pkg::slot_t  push,
	input  wire logic          push_ready
);

	logic                vld_s1;
	hdlcfe_pkg::item_t   item_s1;
	logic                busy_item;
	logic                take;

	assign busy_item = frame_req.has_data | frame_req.frame_first | frame_req.frame_last;
	assign frame_req.ready = !vld_s1 || push_ready;
	assign take = frame_req.valid && frame_req.ready && busy_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (push_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.data_byte   <= frame_req.data_byte;
			item_s1.has_data    <= frame_req.has_data;
			item_s1.frame_first <= frame_req.frame_first;
			item_s1.frame_last  <= frame_req.frame_last;
			item_s1.address     <= frame_req.address;
			item_s1.control     <= frame_req.control;
		end
	end

	assign push.vld  = vld_s1;
	assign push.item = item_s1;

endmodule
`default_nettype wire

@@ rtl/core/hdlcfe_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hdlcfe_queue
// Short FIFO of pending requests between the front and the back end.
// ----------------------------------------------------------------------------
module hdlcfe_queue #(
	parameter int QDEPTH = 2
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire hdlcfe_pkg::slot_t            push,
	output logic                              push_ready,
	output hdlcfe_pkg::slot_t                 head,
	input  wire logic                         pop,
	output logic [$clog2(QDEPTH+1)-1:0]       count
);

	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	hdlcfe_pkg::item_t  mem_q [QDEPTH];
	logic [PW-1:0]      wr_ptr_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [CW-1:0]      cnt_q;
	logic               wr_en;
	logic               rd_en;

	assign push_ready = (cnt_q != CW'(QDEPTH));
	assign wr_en      = push.vld && push_ready;
	assign rd_en      = pop && (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= push.item;
		end
	end

	assign head.vld  = (cnt_q != '0);
	assign head.item = mem_q[rd_ptr_q];
	assign count     = cnt_q;

endmodule
`default_nettype wire

@@ rtl/core/hdlcfe_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hdlcfe_back
// Byte sequencer: walks the head request, stuffs, runs the CRC, drives the line.
// ----------------------------------------------------------------------------
module hdlcfe_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire hdlcfe_pkg::slot_t  head,
	output logic                    pop,
	hdlcfe_out_if.source            line
);

	hdlcfe_pkg::step_t  step_q;
	hdlcfe_pkg::step_t  cur_step;
	hdlcfe_pkg::step_t  nxt_step;
	logic               busy_q;
	logic               stuff_q;
	logic [7:0]         hold_q;
	logic [15:0]        crc_q;
	logic               o_vld_q;
	logic [7:0]         o_byte_q;
	logic               o_last_q;
	logic               o_end_q;

	logic               adv;
	logic [7:0]         b_sel;
	logic               stuffable;
	logic               is_body;
	logic               need_esc;
	logic               last_step;
	logic               done;
	logic [7:0]         emit_byte;

	assign adv = head.vld && (!o_vld_q || line.ready);

	always_comb begin
		if (busy_q) begin
			cur_step = step_q;
		end else if (head.item.frame_first) begin
			cur_step = hdlcfe_pkg::STEP_FLAG_OPEN;
		end else if (head.item.has_data) begin
			cur_step = hdlcfe_pkg::STEP_DATA;
		end else begin
			cur_step = hdlcfe_pkg::STEP_CRC_LO;
		end
	end

	// next state
	always_comb begin
		unique case (cur_step)
			hdlcfe_pkg::STEP_FLAG_OPEN: begin
				nxt_step  = hdlcfe_pkg::STEP_ADDR;
				last_step = 1'b0;
			end
			hdlcfe_pkg::STEP_ADDR: begin
				nxt_step  = hdlcfe_pkg::STEP_ESC_HDR;
				last_step = 1'b0;
			end
			hdlcfe_pkg::STEP_ESC_HDR: begin
				nxt_step  = hdlcfe_pkg::STEP_CTRL;
				last_step = 1'b0;
			end
			hdlcfe_pkg::STEP_CTRL: begin
				nxt_step  = head.item.has_data ? hdlcfe_pkg::STEP_DATA
				                               : hdlcfe_pkg::STEP_CRC_LO;
				last_step = !head.item.has_data && !head.item.frame_last;
			end
			hdlcfe_pkg::STEP_DATA: begin
				nxt_step  = hdlcfe_pkg::STEP_CRC_LO;
				last_step = !head.item.frame_last;
			end
			hdlcfe_pkg::STEP_CRC_LO: begin
				nxt_step  = hdlcfe_pkg::STEP_CRC_HI;
				last_step = 1'b0;
			end
			hdlcfe_pkg::STEP_CRC_HI: begin
				nxt_step  = hdlcfe_pkg::STEP_FLAG_CLOSE;
				last_step = 1'b0;
			end
			hdlcfe_pkg::STEP_FLAG_CLOSE: begin
				nxt_step  = hdlcfe_pkg::STEP_FLAG_CLOSE;
				last_step = 1'b1;
			end
			default: begin
				nxt_step  = hdlcfe_pkg::STEP_FLAG_CLOSE;
				last_step = 1'b1;
			end
		endcase
	end

	// outputs
	always_comb begin
		unique case (cur_step)
			hdlcfe_pkg::STEP_FLAG_OPEN:  b_sel = hdlcfe_pkg::FLAG_BYTE;
			hdlcfe_pkg::STEP_ADDR:       b_sel = head.item.address;
			hdlcfe_pkg::STEP_ESC_HDR:    b_sel = hdlcfe_pkg::ESC_BYTE;
			hdlcfe_pkg::STEP_CTRL:       b_sel = head.item.control;
			hdlcfe_pkg::STEP_DATA:       b_sel = head.item.data_byte;
			hdlcfe_pkg::STEP_CRC_LO:     b_sel = crc_q[7:0];
			hdlcfe_pkg::STEP_CRC_HI:     b_sel = crc_q[15:8];
			hdlcfe_pkg::STEP_FLAG_CLOSE: b_sel = hdlcfe_pkg::FLAG_BYTE;
			default:                     b_sel = hdlcfe_pkg::FLAG_BYTE;
		endcase
		stuffable = (cur_step != hdlcfe_pkg::STEP_FLAG_OPEN) &&
		            (cur_step != hdlcfe_pkg::STEP_FLAG_CLOSE);
		is_body   = (cur_step == hdlcfe_pkg::STEP_ADDR) ||
		            (cur_step == hdlcfe_pkg::STEP_ESC_HDR) ||
		            (cur_step == hdlcfe_pkg::STEP_CTRL) ||
		            (cur_step == hdlcfe_pkg::STEP_DATA);
		need_esc  = !stuff_q && stuffable &&
		            ((b_sel == hdlcfe_pkg::FLAG_BYTE) || (b_sel == hdlcfe_pkg::ESC_BYTE));
		done      = !need_esc && last_step;
		if (stuff_q) begin
			emit_byte = hold_q;
		end else if (need_esc) begin
			emit_byte = hdlcfe_pkg::ESC_BYTE;
		end else begin
			emit_byte = b_sel;
		end
	end

	assign pop = adv && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			stuff_q <= 1'b0;
			step_q  <= hdlcfe_pkg::STEP_FLAG_OPEN;
			crc_q   <= hdlcfe_pkg::CRC_INIT;
			o_vld_q <= 1'b0;
		end else begin
			if (adv) begin
				if (need_esc) begin
					stuff_q <= 1'b1;
					busy_q  <= 1'b1;
					step_q  <= cur_step;
				end else begin
					stuff_q <= 1'b0;
					busy_q  <= !done;
					step_q  <= nxt_step;
				end
				if ((cur_step == hdlcfe_pkg::STEP_FLAG_OPEN) ||
				    (cur_step == hdlcfe_pkg::STEP_FLAG_CLOSE)) begin
					crc_q <= hdlcfe_pkg::CRC_INIT;
				end else if (is_body && !stuff_q) begin
					crc_q <= hdlcfe_pkg::crc_update(crc_q, b_sel);
				end
				o_vld_q <= 1'b1;
			end else if (line.ready) begin
				o_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (need_esc && adv) begin
			hold_q <= b_sel ^ hdlcfe_pkg::STUFF_XOR;
		end
		if (adv) begin
			o_byte_q <= emit_byte;
			o_last_q <= done;
			o_end_q  <= (cur_step == hdlcfe_pkg::STEP_FLAG_CLOSE);
		end
	end

	assign line.valid     = o_vld_q;
	assign line.out_byte  = o_byte_q;
	assign line.run_last  = o_last_q;
	assign line.frame_end = o_end_q;

endmodule
`default_nettype wire

@@ rtl/core/hdlc_frame_encoder_crc16_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hdlc_frame_encoder_crc16_core
// Path: front stage register, then queue, then back-end output register.
// Throughput: one line byte per cycle while a request is queued and the line is
// ready (back-end sequencer); a request yields 1 to 14 bytes, an idle one none.
// Reset: asynchronous, clears the queue and output valid, CRC back to 0xFFFF.
// ----------------------------------------------------------------------------
module hdlc_frame_encoder_crc16_core #(
	parameter int QDEPTH = 2
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	hdlcfe_in_if.sink  frame_req,
	hdlcfe_out_if.source line
);

	localparam int CW = $clog2(QDEPTH + 1);

	hdlcfe_pkg::slot_t  push;
	hdlcfe_pkg::slot_t  head;
	logic               push_ready;
	logic               pop;
	logic [CW-1:0]      q_count;

	hdlcfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_req  (frame_req),
		.push       (push),
		.push_ready (push_ready)
	);

	hdlcfe_queue #(
		.QDEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.head       (head),
		.pop        (pop),
		.count      (q_count)
	);

	hdlcfe_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.line   (line)
	);

	a_close_flag : assert property (@(posedge clk) disable iff (!arst_n)
		line.valid && line.frame_end |->
			line.run_last && (line.out_byte == hdlcfe_pkg::FLAG_BYTE))
		else $error("closing flag malformed");

	a_queue_bound : assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= CW'(QDEPTH))
		else $error("queue count overflow");

	a_escape_pair : assert property (@(posedge clk) disable iff (!arst_n)
		line.valid && line.ready && (line.out_byte == hdlcfe_pkg::ESC_BYTE) |->
			!line.run_last ##1 line.valid &&
			((line.out_byte == 8'h5E) || (line.out_byte == 8'h5D)))
		else $error("escape not followed by stuffed byte");

endmodule
`default_nettype wire

@@ verif/hdlc_frame_encoder_crc16_core_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hdlc_frame_encoder_crc16_core_tb
// Drives frame requests into the encoder and predicts every line byte: header,
// stuffed payload, CRC-16/Modbus (low byte first) and the closing flag. Each
// line byte is compared field by field with the oldest prediction while both
// channels stall at random, and in a last random run with neither stalling.
// ----------------------------------------------------------------------------
module hdlc_frame_encoder_crc16_core_tb;
	import hdlcfe_pkg::*;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       frame_end;
	} line_byte_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	hdlcfe_in_if  frame_req ();
	hdlcfe_out_if line ();

	hdlc_frame_encoder_crc16_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame_req (frame_req.sink),
		.line      (line.source)
	);

	logic [15:0] crc_acc = CRC_INIT;
	line_byte_t  line_bytes_due[$];
	line_byte_t  request_bytes[$];

	int req_gap_pct     = 11;
	int line_stall_pct  = 74;
	int requests_sent   = 0;
	int bytes_checked   = 0;
	int frames_closed   = 0;
	int mismatch_count  = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [15:0] crc16_modbus_byte(logic [15:0] acc, logic [7:0] b);
		logic [15:0] r;
		r = acc ^ {8'h00, b};
		repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		return r;
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
			0: return FLAG_BYTE;
			1: return ESC_BYTE;
			2: return ($urandom_range(1) == 0) ? 8'h00 : 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic item_t make_req(logic first, logic last, logic has,
			logic [7:0] data, logic [7:0] addr, logic [7:0] ctrl);
		item_t r;
		r.data_byte   = data;
		r.has_data    = has;
		r.frame_first = first;
		r.frame_last  = last;
		r.address     = addr;
		r.control     = ctrl;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic push_raw(input logic [7:0] b, input logic fe);
		request_bytes.push_back('{out_byte: b, run_last: 1'b0, frame_end: fe});
	endtask

	task automatic push_stuffed(input logic [7:0] b);
		if (b == FLAG_BYTE || b == ESC_BYTE) begin
			push_raw(ESC_BYTE, 1'b0);
			push_raw(b ^ STUFF_XOR, 1'b0);
		end else begin
			push_raw(b, 1'b0);
		end
	endtask

	task automatic push_body(input logic [7:0] b);
		crc_acc = crc16_modbus_byte(crc_acc, b);
		push_stuffed(b);
	endtask

	task automatic encode_request(input item_t r);
		line_byte_t lb;
		request_bytes.delete();
		if (r.frame_first) begin
			crc_acc = CRC_INIT;
			push_raw(FLAG_BYTE, 1'b0);
			push_body(r.address);
			push_body(ESC_BYTE);
			push_body(r.control);
		end
		if (r.has_data) begin
			push_body(r.data_byte);
		end
		if (r.frame_last) begin
			push_stuffed(crc_acc[7:0]);
			push_stuffed(crc_acc[15:8]);
			push_raw(FLAG_BYTE, 1'b1);
			crc_acc = CRC_INIT;
		end
		while (request_bytes.size() > 0) begin
			lb = request_bytes.pop_front();
			lb.run_last = (request_bytes.size() == 0);
			line_bytes_due.push_back(lb);
		end
	endtask

	task automatic send_request(input item_t req);
		while ($urandom_range(99) < req_gap_pct) begin
			frame_req.valid <= 1'b0;
			@(posedge clk);
		end
		frame_req.valid       <= 1'b1;
		frame_req.data_byte   <= req.data_byte;
		frame_req.has_data    <= req.has_data;
		frame_req.frame_first <= req.frame_first;
		frame_req.frame_last  <= req.frame_last;
		frame_req.address     <= req.address;
		frame_req.control     <= req.control;
		do @(posedge clk); while (!frame_req.ready);
		encode_request(req);
		requests_sent++;
	endtask

	always @(posedge clk) begin
		line_byte_t exp_b;
		if (arst_n && line.valid && line.ready) begin
			bytes_checked++;
			if (line_bytes_due.size() == 0) begin
				report_mismatch($sformatf("line byte %02h with nothing expected", line.out_byte));
			end else begin
				exp_b = line_bytes_due.pop_front();
				if (line.out_byte !== exp_b.out_byte)
					report_mismatch($sformatf("out_byte %02h, expected %02h",
						line.out_byte, exp_b.out_byte));
				if (line.run_last !== exp_b.run_last)
					report_mismatch($sformatf("run_last %b, expected %b on byte %02h",
						line.run_last, exp_b.run_last, exp_b.out_byte));
				if (line.frame_end !== exp_b.frame_end)
					report_mismatch($sformatf("frame_end %b, expected %b on byte %02h",
						line.frame_end, exp_b.frame_end, exp_b.out_byte));
				if (exp_b.frame_end)
					frames_closed++;
			end
		end
		line.ready <= ($urandom_range(99) >= line_stall_pct);
	end

	task automatic test_directed();
		send_request(make_req(0, 0, 1, 8'h00, 8'hA5, 8'h5A));
		send_request(make_req(0, 1, 0, 8'hC3, 8'h3C, 8'h96));
		send_request(make_req(0, 0, 0, 8'hFF, 8'hFF, 8'hFF));
		send_request(make_req(1, 0, 0, 8'h11, 8'h00, 8'h00));
		send_request(make_req(0, 0, 1, 8'hFF, 8'h77, 8'h88));
		send_request(make_req(0, 0, 1, FLAG_BYTE, 8'h00, 8'h00));
		send_request(make_req(0, 1, 1, ESC_BYTE, 8'hFF, 8'hFF));
		send_request(make_req(1, 1, 0, 8'h42, 8'hFF, 8'hFF));
		send_request(make_req(1, 0, 1, FLAG_BYTE, FLAG_BYTE, ESC_BYTE));
		send_request(make_req(1, 1, 1, ESC_BYTE, ESC_BYTE, FLAG_BYTE));
		send_request(make_req(0, 0, 1, 8'h5A, 8'h12, 8'h34));
		send_request(make_req(0, 1, 1, 8'h20, 8'h56, 8'h78));
		send_request(make_req(1, 1, 1, 8'h00, 8'h80, 8'h01));
		send_request(make_req(0, 0, 0, 8'h00, 8'h00, 8'h00));
		send_request(make_req(1, 1, 1, 8'h5E, STUFF_XOR, 8'h5D));
	endtask

	// find frames whose CRC low or high byte needs stuffing
	task automatic test_crc_stuffing();
		logic [15:0] c;
		logic [7:0]  crc_b;
		logic        found;
		for (int lane = 0; lane < 2; lane++) begin
			found = 1'b0;
			for (int a = 0; a < 256 && !found; a++) begin
				for (int d = 0; d < 256 && !found; d++) begin
					c = crc16_modbus_byte(CRC_INIT, 8'(a));
					c = crc16_modbus_byte(c, ESC_BYTE);
					c = crc16_modbus_byte(c, 8'h3C);
					c = crc16_modbus_byte(c, 8'(d));
					crc_b = (lane == 0) ? c[7:0] : c[15:8];
					if (crc_b == FLAG_BYTE || crc_b == ESC_BYTE) begin
						found = 1'b1;
						send_request(make_req(1, 1, 1, 8'(d), 8'(a), 8'h3C));
					end
				end
			end
		end
	endtask

	task automatic test_random_frames(input int count);
		int     sent;
		int     n_items;
		logic   broken;
		logic   first;
		logic   last;
		logic   has;
		item_t  req;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(9) < 8) begin
				n_items = $urandom_range(1, 6);
				broken  = ($urandom_range(9) == 0);
				for (int i = 0; i < n_items; i++) begin
					first = (i == 0) && !(broken && $urandom_range(1));
					last  = (i == n_items - 1) && !broken;
					has   = (i == 0 || i == n_items - 1) ? 1'($urandom_range(1)) : 1'b1;
					if (!first && !last)
						has = 1'b1;
					send_request(make_req(first, last, has, pick_byte(), pick_byte(),
						pick_byte()));
					sent++;
				end
			end else begin
				req = item_t'({$urandom, $urandom});
				send_request(req);
				if (req.has_data || req.frame_first || req.frame_last)
					sent++;
			end
		end
	endtask

	task automatic wait_drained();
		while (line_bytes_due.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	initial begin
		frame_req.valid       = 1'b0;
		frame_req.data_byte   = 8'h00;
		frame_req.has_data    = 1'b0;
		frame_req.frame_first = 1'b0;
		frame_req.frame_last  = 1'b0;
		frame_req.address     = 8'h00;
		frame_req.control     = 8'h00;
		line.ready            = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_crc_stuffing();
		test_random_frames(148);
		req_gap_pct    = 74;
		line_stall_pct = 11;
		test_random_frames(148);
		req_gap_pct    = 0;
		line_stall_pct = 0;
		test_random_frames(148);
		frame_req.valid <= 1'b0;
		wait_drained();

		$display("Covered %0d requests (directed, CRC stuffing, random frames and noise)",
			requests_sent);
		$display("Checked %0d line bytes across %0d closed frames", bytes_checked,
			frames_closed);
		if (mismatch_count == 0) begin
			$display("hdlc_frame_encoder_crc16_core_tb passed");
		end else begin
			$display("hdlc_frame_encoder_crc16_core_tb failed");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timeout with %0d line bytes outstanding", line_bytes_due.size());
		$display("hdlc_frame_encoder_crc16_core_tb failed");
		$finish;
	end

endmodule
`default_nettype wire

@@ files.f @@
rtl/core/hdlcfe_pkg.sv
rtl/core/hdlcfe_in_if.sv
rtl/core/hdlcfe_out_if.sv
rtl/core/hdlcfe_front.sv
rtl/core/hdlcfe_queue.sv
rtl/core/hdlcfe_back.sv
rtl/core/hdlc_frame_encoder_crc16_core.sv
verif/hdlc_frame_encoder_crc16_core_tb.sv
